// ----- rtl/mmprng_pkg.sv -----
// Package for the multi-mode pseudo-random generator.
// Holds mode codes, generator constants, boost cut tables and shared types.
// No dependencies.
package mmprng_pkg;

   localparam logic [2:0] MODE_XORSHIFT     = 3'd0;
   localparam logic [2:0] MODE_MINSTD       = 3'd1;
   localparam logic [2:0] MODE_LCG31        = 3'd2;
   localparam logic [2:0] MODE_LCG15        = 3'd3;
   localparam logic [2:0] MODE_LCG48        = 3'd4;
   localparam logic [2:0] MODE_PCG32        = 3'd5;
   localparam logic [2:0] MODE_SPLITMIX     = 3'd6;
   localparam logic [2:0] MODE_SPLITMIX_ALT = 3'd7;

   localparam logic KIND_RESEED = 1'b0;
   localparam logic KIND_DRAW   = 1'b1;

   localparam logic REDUCE_MOD   = 1'b0;
   localparam logic REDUCE_SCALE = 1'b1;

   localparam logic REG_GEN_MODE    = 1'b0;
   localparam logic REG_REDUCE_MODE = 1'b1;

   localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
   localparam logic [63:0] PCG_INC  = 64'd1442695040888963407;
   localparam logic [63:0] L48_MULT = 64'h5DEECE66D;
   localparam logic [63:0] L48_ADD  = 64'hB;
   localparam logic [63:0] L48_MASK = 64'hFFFFFFFFFFFF;
   localparam logic [63:0] MS_MULT  = 64'd48271;
   localparam logic [31:0] MS_MOD   = 32'd2147483647;
   localparam logic [63:0] LCG31_MULT = 64'd1103515245;
   localparam logic [63:0] LCG31_ADD  = 64'd12345;
   localparam logic [63:0] LCG15_MULT = 64'd214013;
   localparam logic [63:0] LCG15_ADD  = 64'd2531011;
   localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] SM_MIX1  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] SM_MIX2  = 64'h94D049BB133111EB;

   localparam int NUM_CUTS = 5;
   localparam logic [2:0] BOOST_NONE = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_REDUCE,
      ST_OUT
   } fsm_state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] value;
      logic [2:0]  mode;
      logic        reduce_mode;
   } red_req_type;

   function automatic logic [63:0] cut_calc(logic [71:0] range, int idx);
      logic [71:0] r;
      begin
         r = '0;
         case (idx)
            0: r = (range * 72'd64) / 72'd125;
            1: r = (range * 72'd3) / 72'd4;
            2: r = (range * 72'd9) / 72'd10;
            3: r = (range * 72'd19) / 72'd20;
            default: r = (range * 72'd39) / 72'd40;
         endcase
         return r[63:0];
      end
   endfunction

   localparam logic [71:0] RANGE_32 = 72'd4294967296;
   localparam logic [71:0] RANGE_MS = 72'd2147483647;
   localparam logic [71:0] RANGE_31 = 72'd2147483648;
   localparam logic [71:0] RANGE_15 = 72'd32768;
   localparam logic [71:0] RANGE_64 = 72'd1 << 64;

   localparam logic [63:0] CUT_32 [0:4] = '{cut_calc(RANGE_32, 0), cut_calc(RANGE_32, 1),
      cut_calc(RANGE_32, 2), cut_calc(RANGE_32, 3), cut_calc(RANGE_32, 4)};
   localparam logic [63:0] CUT_MS [0:4] = '{cut_calc(RANGE_MS, 0), cut_calc(RANGE_MS, 1),
      cut_calc(RANGE_MS, 2), cut_calc(RANGE_MS, 3), cut_calc(RANGE_MS, 4)};
   localparam logic [63:0] CUT_31 [0:4] = '{cut_calc(RANGE_31, 0), cut_calc(RANGE_31, 1),
      cut_calc(RANGE_31, 2), cut_calc(RANGE_31, 3), cut_calc(RANGE_31, 4)};
   localparam logic [63:0] CUT_15 [0:4] = '{cut_calc(RANGE_15, 0), cut_calc(RANGE_15, 1),
      cut_calc(RANGE_15, 2), cut_calc(RANGE_15, 3), cut_calc(RANGE_15, 4)};
   localparam logic [63:0] CUT_64 [0:4] = '{cut_calc(RANGE_64, 0), cut_calc(RANGE_64, 1),
      cut_calc(RANGE_64, 2), cut_calc(RANGE_64, 3), cut_calc(RANGE_64, 4)};

   function automatic logic [63:0] cut_threshold(logic [2:0] mode, logic [2:0] idx);
      logic [63:0] t;
      begin
         t = '1;
         if (idx < 3'(NUM_CUTS)) begin
            case (mode)
               MODE_MINSTD: t = CUT_MS[idx];
               MODE_LCG31:  t = CUT_31[idx];
               MODE_LCG15:  t = CUT_15[idx];
               MODE_XORSHIFT, MODE_LCG48, MODE_PCG32: t = CUT_32[idx];
               default: t = CUT_64[idx];
            endcase
         end
         return t;
      end
   endfunction

   function automatic logic [31:0] xorshift_step(logic [31:0] x0);
      logic [31:0] x;
      begin
         x = x0 ^ (x0 << 13);
         x = x ^ (x >> 17);
         x = x ^ (x << 5);
         return x;
      end
   endfunction

   function automatic logic [31:0] minstd_fold(logic [47:0] p);
      logic [31:0] f;
      begin
         f = 32'(p[30:0]) + 32'(p[47:31]);
         if (f >= MS_MOD) begin
            f = f - MS_MOD;
         end
         return f;
      end
   endfunction

   function automatic logic [63:0] seed_state(logic [2:0] mode, logic [31:0] seed);
      logic [63:0] s;
      logic [31:0] f;
      begin
         s = {32'd0, seed};
         f = 32'(seed[30:0]) + 32'(seed[31]);
         if (f >= MS_MOD) begin
            f = f - MS_MOD;
         end
         case (mode)
            MODE_XORSHIFT: s = (seed == 32'd0) ? 64'd1 : {32'd0, seed};
            MODE_MINSTD:   s = (f == 32'd0) ? 64'd1 : {32'd0, f};
            MODE_LCG48:    s = ({32'd0, seed} ^ L48_MULT) & L48_MASK;
            default:       s = {32'd0, seed};
         endcase
         return s;
      end
   endfunction

   function automatic logic [31:0] pcg_output(logic [63:0] o);
      logic [31:0] xs;
      logic [63:0] dbl;
      begin
         xs = 32'(((o >> 18) ^ o) >> 27);
         dbl = {xs, xs} >> o[63:59];
         return dbl[31:0];
      end
   endfunction

endpackage

// ----- rtl/mmprng_mul.sv -----
// Shared 64-bit multiply-add unit: result = a * b + c modulo 2^64.
// Uses one 32x32 multiplier over three partial products.
// Depends on mmprng_pkg.
module mmprng_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  mmprng_pkg::mul_req_type  req,
   output logic                     done,
   output logic [63:0]              result
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_a, mul_b;

   assign mul_a = (step_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
   assign mul_b = (step_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = req.c;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = 64'(mul_a) * 64'(mul_b);
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = acc_ff + prod_ff;
            default: acc_in = acc_ff + (prod_ff << 32);
         endcase
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ----- rtl/mmprng_reduce.sv -----
// Range reduction unit: position by byte-serial modulo 20 or by scaling,
// and boost class by one cut compare per cycle.
// Depends on mmprng_pkg.
module mmprng_reduce (
   input  logic                     clock,
   input  logic                     reset,
   input  mmprng_pkg::red_req_type  req,
   output logic                     done,
   output logic [4:0]               position,
   output logic [2:0]               boost_class
);

   logic [63:0] val_ff, val_in;
   logic [63:0] sh_ff, sh_in;
   logic [2:0]  mode_ff, mode_in;
   logic        rmode_ff, rmode_in;
   logic [4:0]  rem_ff, rem_in;
   logic [2:0]  cls_ff, cls_in;
   logic        found_ff, found_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [4:0]  pos_ff, pos_in;
   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;
   logic        done_ff, done_in;

   logic [12:0] x;
   logic [24:0] recip;
   logic [8:0]  q;
   logic [4:0]  rem_next;
   logic [68:0] t;
   logic [31:0] ms_r;
   logic [4:0]  scaled;

   assign x        = {rem_ff, 8'd0} + 13'(sh_ff[63:56]);
   assign recip    = 25'(x) * 25'd3277;
   assign q        = recip[24:16];
   assign rem_next = 5'(x - 13'(q) * 13'd20);
   assign t        = ({5'd0, val_ff} << 4) + ({5'd0, val_ff} << 2);
   assign ms_r     = 32'(t[30:0]) + 32'(t[35:31]);

   always_comb begin
      case (mode_ff)
         mmprng_pkg::MODE_XORSHIFT, mmprng_pkg::MODE_LCG48,
         mmprng_pkg::MODE_PCG32: scaled = t[36:32];
         mmprng_pkg::MODE_LCG31: scaled = t[35:31];
         mmprng_pkg::MODE_LCG15: scaled = t[19:15];
         mmprng_pkg::MODE_MINSTD:
            scaled = t[35:31] + ((ms_r >= mmprng_pkg::MS_MOD) ? 5'd1 : 5'd0);
         default: scaled = t[68:64];
      endcase
   end

   always_comb begin
      val_in   = val_ff;
      sh_in    = sh_ff;
      mode_in  = mode_ff;
      rmode_in = rmode_ff;
      rem_in   = rem_ff;
      cls_in   = cls_ff;
      found_in = found_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      if (req.start) begin
         val_in   = req.value;
         sh_in    = req.value;
         mode_in  = req.mode;
         rmode_in = req.reduce_mode;
         rem_in   = 5'd0;
         cls_in   = mmprng_pkg::BOOST_NONE;
         found_in = 1'b0;
         cnt_in   = 3'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         sh_in  = sh_ff << 8;
         rem_in = rem_next;
         cnt_in = cnt_ff + 3'd1;
         if (!found_ff && val_ff < mmprng_pkg::cut_threshold(mode_ff, cnt_ff)) begin
            cls_in   = cnt_ff;
            found_in = 1'b1;
         end
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         pos_in  = (rmode_ff == mmprng_pkg::REDUCE_SCALE) ? scaled : rem_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      sh_ff    <= sh_in;
      mode_ff  <= mode_in;
      rmode_ff <= rmode_in;
      rem_ff   <= rem_in;
      cls_ff   <= cls_in;
      found_ff <= found_in;
      cnt_ff   <= cnt_in;
      pos_ff   <= pos_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done        = done_ff;
   assign position    = pos_ff;
   assign boost_class = cls_ff;

endmodule

// ----- rtl/multi_mode_prng_with_range_reduce.sv -----
// Top level of the multi-mode pseudo-random generator with range reduction.
// Instantiates mmprng_mul and mmprng_reduce; depends on mmprng_pkg.
//
// The request stream carries one item per handshake: tuser is the kind
// (reseed or draw) and tdata the 32-bit seed. A reseed item loads the
// generator state by the seeding rule of the selected mode and gives no
// result. A draw item advances the state and gives one response item with
// the raw output, a position 0..19 and a boost class 0..5.
// Two registers on the APB-style port select the generator and the
// position reduction; write them only while the block is idle.
// A reseed loads the state directly, except for pcg32, where it first runs
// one multiply-add. A draw runs no multiply-add for xorshift32, one for the
// other modes and two for splitmix64, each on the shared 32x32 multiplier;
// then the reduction unit takes eight byte steps, one to finish and one to
// register, and the output stage registers the response item.
// The block takes one item at a time; req_tready is high only while idle and
// rises again in the cycle the response valid rises.
// Reset clears the state, both registers and the response valid.
// When the receiver stalls, the response item is held in the output
// register and the block waits with its next result until it is taken.
module multi_mode_prng_with_range_reduce (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] raw_output, [68:64] position, [71:69] boost_class
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mmprng_pkg::fsm_state_type fsm_ff, fsm_in;
   logic [63:0] gen_state_ff, gen_state_in;
   logic [63:0] val_ff, val_in;
   logic        seeding_ff, seeding_in;
   logic [2:0]  mode_ff, mode_in;
   logic [4:0]  pos_ff, pos_in;
   logic [2:0]  cls_ff, cls_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  gen_mode_ff;
   logic        red_mode_ff;

   mmprng_pkg::mul_req_type mul_req;
   mmprng_pkg::red_req_type red_req;
   logic        mul_done;
   logic [63:0] mul_res;
   logic        red_done;
   logic [4:0]  red_pos;
   logic [2:0]  red_cls;

   logic        req_accept;
   logic        csr_write;
   logic        out_free;
   logic [31:0] xs_next;
   logic [63:0] sm_z;
   logic [31:0] ms_val;
   logic [63:0] l48_val;

   assign req_tready = (fsm_ff == mmprng_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign xs_next    = mmprng_pkg::xorshift_step(gen_state_ff[31:0]);
   assign sm_z       = gen_state_ff + mmprng_pkg::SM_GAMMA;
   assign ms_val     = mmprng_pkg::minstd_fold(mul_res[47:0]);
   assign l48_val    = mul_res & mmprng_pkg::L48_MASK;

   always_comb begin
      csr_prdata = 32'd0;
      unique case (csr_paddr[2])
         mmprng_pkg::REG_GEN_MODE:    csr_prdata = {29'd0, gen_mode_ff};
         mmprng_pkg::REG_REDUCE_MODE: csr_prdata = {31'd0, red_mode_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   mmprng_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   mmprng_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .req         (red_req),
      .done        (red_done),
      .position    (red_pos),
      .boost_class (red_cls)
   );

   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         mmprng_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == mmprng_pkg::KIND_RESEED) begin
                  if (gen_mode_ff == mmprng_pkg::MODE_PCG32) begin
                     fsm_in = mmprng_pkg::ST_MUL1;
                  end
               end else if (gen_mode_ff == mmprng_pkg::MODE_XORSHIFT) begin
                  fsm_in = mmprng_pkg::ST_REDUCE;
               end else begin
                  fsm_in = mmprng_pkg::ST_MUL1;
               end
            end
         end
         mmprng_pkg::ST_MUL1: begin
            if (mul_done) begin
               if (seeding_ff) begin
                  fsm_in = mmprng_pkg::ST_IDLE;
               end else if (mode_ff == mmprng_pkg::MODE_SPLITMIX ||
                            mode_ff == mmprng_pkg::MODE_SPLITMIX_ALT) begin
                  fsm_in = mmprng_pkg::ST_MUL2;
               end else begin
                  fsm_in = mmprng_pkg::ST_REDUCE;
               end
            end
         end
         mmprng_pkg::ST_MUL2: begin
            if (mul_done) begin
               fsm_in = mmprng_pkg::ST_REDUCE;
            end
         end
         mmprng_pkg::ST_REDUCE: begin
            if (red_done) begin
               fsm_in = mmprng_pkg::ST_OUT;
            end
         end
         mmprng_pkg::ST_OUT: begin
            if (out_free) begin
               fsm_in = mmprng_pkg::ST_IDLE;
            end
         end
         default: fsm_in = mmprng_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      gen_state_in = gen_state_ff;
      val_in       = val_ff;
      seeding_in   = seeding_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      cls_in       = cls_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;
      red_req      = '0;
      unique case (fsm_ff)
         mmprng_pkg::ST_IDLE: begin
            if (req_accept) begin
               mode_in    = gen_mode_ff;
               seeding_in = (req_tuser == mmprng_pkg::KIND_RESEED);
               if (req_tuser == mmprng_pkg::KIND_RESEED) begin
                  if (gen_mode_ff == mmprng_pkg::MODE_PCG32) begin
                     mul_req.start = 1'b1;
                     mul_req.a     = mmprng_pkg::PCG_INC + {32'd0, req_tdata};
                     mul_req.b     = mmprng_pkg::PCG_MULT;
                     mul_req.c     = mmprng_pkg::PCG_INC;
                  end else begin
                     gen_state_in = mmprng_pkg::seed_state(gen_mode_ff, req_tdata);
                  end
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = {32'd0, gen_state_ff[31:0]};
                  case (gen_mode_ff)
                     mmprng_pkg::MODE_XORSHIFT: begin
                        mul_req.start = 1'b0;
                        gen_state_in  = {32'd0, xs_next};
                        val_in        = {32'd0, xs_next};
                     end
                     mmprng_pkg::MODE_MINSTD: begin
                        mul_req.b = mmprng_pkg::MS_MULT;
                     end
                     mmprng_pkg::MODE_LCG31: begin
                        mul_req.b = mmprng_pkg::LCG31_MULT;
                        mul_req.c = mmprng_pkg::LCG31_ADD;
                     end
                     mmprng_pkg::MODE_LCG15: begin
                        mul_req.b = mmprng_pkg::LCG15_MULT;
                        mul_req.c = mmprng_pkg::LCG15_ADD;
                     end
                     mmprng_pkg::MODE_LCG48: begin
                        mul_req.a = gen_state_ff;
                        mul_req.b = mmprng_pkg::L48_MULT;
                        mul_req.c = mmprng_pkg::L48_ADD;
                     end
                     mmprng_pkg::MODE_PCG32: begin
                        mul_req.a = gen_state_ff;
                        mul_req.b = mmprng_pkg::PCG_MULT;
                        mul_req.c = mmprng_pkg::PCG_INC;
                        val_in    = {32'd0, mmprng_pkg::pcg_output(gen_state_ff)};
                     end
                     default: begin
                        gen_state_in = sm_z;
                        mul_req.a    = sm_z ^ (sm_z >> 30);
                        mul_req.b    = mmprng_pkg::SM_MIX1;
                     end
                  endcase
                  red_req.start = (gen_mode_ff == mmprng_pkg::MODE_XORSHIFT);
               end
            end
         end
         mmprng_pkg::ST_MUL1: begin
            if (mul_done) begin
               if (seeding_ff) begin
                  gen_state_in = mul_res;
               end else begin
                  red_req.start = 1'b1;
                  case (mode_ff)
                     mmprng_pkg::MODE_MINSTD: begin
                        gen_state_in = {32'd0, ms_val};
                        val_in       = {32'd0, ms_val};
                     end
                     mmprng_pkg::MODE_LCG31: begin
                        gen_state_in = {32'd0, mul_res[31:0]};
                        val_in       = {33'd0, mul_res[31:1]};
                     end
                     mmprng_pkg::MODE_LCG15: begin
                        gen_state_in = {32'd0, mul_res[31:0]};
                        val_in       = {49'd0, mul_res[30:16]};
                     end
                     mmprng_pkg::MODE_LCG48: begin
                        gen_state_in = l48_val;
                        val_in       = l48_val >> 16;
                     end
                     mmprng_pkg::MODE_PCG32: begin
                        gen_state_in = mul_res;
                     end
                     default: begin
                        red_req.start = 1'b0;
                        mul_req.start = 1'b1;
                        mul_req.a     = mul_res ^ (mul_res >> 27);
                        mul_req.b     = mmprng_pkg::SM_MIX2;
                     end
                  endcase
               end
            end
         end
         mmprng_pkg::ST_MUL2: begin
            if (mul_done) begin
               val_in        = mul_res ^ (mul_res >> 31);
               red_req.start = 1'b1;
            end
         end
         mmprng_pkg::ST_REDUCE: begin
            if (red_done) begin
               pos_in = red_pos;
               cls_in = red_cls;
            end
         end
         mmprng_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cls_ff, pos_ff, val_ff};
            end
         end
         default: rsp_valid_in = rsp_valid_ff && !rsp_tready;
      endcase
      red_req.value       = val_in;
      red_req.mode        = mode_in;
      red_req.reduce_mode = red_mode_ff;
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      mode_ff     <= mode_in;
      pos_ff      <= pos_in;
      cls_ff      <= cls_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         fsm_ff       <= mmprng_pkg::ST_IDLE;
         gen_state_ff <= 64'd0;
         seeding_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gen_mode_ff  <= 3'd0;
         red_mode_ff  <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         gen_state_ff <= gen_state_in;
         seeding_ff   <= seeding_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            if (csr_paddr[2] == mmprng_pkg::REG_GEN_MODE) begin
               gen_mode_ff <= csr_pwdata[2:0];
            end else begin
               red_mode_ff <= csr_pwdata[0];
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/mmprng_checker.sv -----
// Port-level checker for the multi-mode generator top level.
// Bound to multi_mode_prng_with_range_reduce; no package dependency.
module mmprng_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response item changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[68:64] <= 5'd19)
      else $error("Position out of range.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:69] <= 3'd5)
      else $error("Boost class out of range.");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("Response item appeared while the block was idle.");

endmodule

bind multi_mode_prng_with_range_reduce mmprng_checker u_mmprng_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for multi_mode_prng_with_range_reduce.
// Drives seed and draw items under random stalls, predicts every result in SV.
// Depends on mmprng_pkg and the RTL of the block.
module testbench;

   localparam logic [2:0] ADDR_GEN_MODE    = 3'd0;
   localparam logic [2:0] ADDR_REDUCE_MODE = 3'd4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [2:0]  boost;
      logic [4:0]  pos;
      logic [63:0] raw;
   } draw_result_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] seed;
      logic [2:0]  gen_mode;
      logic        red_mode;
      logic        typed;
      logic [63:0] raw;
      logic [4:0]  pos;
      logic [2:0]  boost;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   draw_result_type pending_draws[$];
   logic [63:0] gen_state;
   logic [2:0]  cur_gen_mode;
   logic        cur_red_mode;
   logic        quiet;
   int          cycles;
   int          mismatches;
   stim_row_type rows[0:21];

   multi_mode_prng_with_range_reduce DUT (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [2:0] boost_class_of(logic [2:0] mode, logic [63:0] v);
      logic [127:0] span;
      logic [127:0] num [0:4];
      logic [127:0] den [0:4];
      begin
         num = '{128'd64, 128'd3, 128'd9, 128'd19, 128'd39};
         den = '{128'd125, 128'd4, 128'd10, 128'd20, 128'd40};
         case (mode)
            mmprng_pkg::MODE_MINSTD: span = 128'd2147483647;
            mmprng_pkg::MODE_LCG31:  span = 128'd2147483648;
            mmprng_pkg::MODE_LCG15:  span = 128'd32768;
            mmprng_pkg::MODE_XORSHIFT, mmprng_pkg::MODE_LCG48,
            mmprng_pkg::MODE_PCG32: span = 128'd4294967296;
            default: span = 128'd1 << 64;
         endcase
         for (int i = 0; i < 5; i++) begin
            if (mode >= mmprng_pkg::MODE_SPLITMIX) begin
               if (v != '1 && (128'(v) + 128'd1) * den[i] <= (num[i] << 64)) return 3'(i);
            end else if (128'(v) < (span * num[i]) / den[i]) begin
               return 3'(i);
            end
         end
         return mmprng_pkg::BOOST_NONE;
      end
   endfunction

   function automatic logic [4:0] position_of(logic [2:0] mode, logic red, logic [63:0] v);
      logic [127:0] span;
      begin
         case (mode)
            mmprng_pkg::MODE_MINSTD: span = 128'd2147483647;
            mmprng_pkg::MODE_LCG31:  span = 128'd2147483648;
            mmprng_pkg::MODE_LCG15:  span = 128'd32768;
            mmprng_pkg::MODE_XORSHIFT, mmprng_pkg::MODE_LCG48,
            mmprng_pkg::MODE_PCG32: span = 128'd4294967296;
            default: span = 128'd1 << 64;
         endcase
         if (red == mmprng_pkg::REDUCE_MOD) return 5'(v % 64'd20);
         return 5'((128'(v) * 128'd20) / span);
      end
   endfunction

   // Updates the generator state and returns the draw result, if any.
   task automatic predict_item(input logic kind, input logic [31:0] seed,
         output logic produced, output draw_result_type res);
      logic [31:0]  x;
      logic [31:0]  xs;
      logic [4:0]   r;
      logic [63:0]  s;
      logic [63:0]  v;
      begin
         produced = 1'b0;
         res = '0;
         x = gen_state[31:0];
         if (kind == mmprng_pkg::KIND_RESEED) begin
            case (cur_gen_mode)
               mmprng_pkg::MODE_XORSHIFT: gen_state = (seed == 0) ? 64'd1 : 64'(seed);
               mmprng_pkg::MODE_MINSTD: begin
                  s = 64'(seed) % 64'd2147483647;
                  gen_state = (s == 0) ? 64'd1 : s;
               end
               mmprng_pkg::MODE_LCG48:
                  gen_state = (64'(seed) ^ mmprng_pkg::L48_MULT) & mmprng_pkg::L48_MASK;
               mmprng_pkg::MODE_PCG32:
                  gen_state = (mmprng_pkg::PCG_INC + 64'(seed)) * mmprng_pkg::PCG_MULT
                     + mmprng_pkg::PCG_INC;
               default: gen_state = 64'(seed);
            endcase
         end else begin
            case (cur_gen_mode)
               mmprng_pkg::MODE_XORSHIFT: begin
                  x = x ^ (x << 13);
                  x = x ^ (x >> 17);
                  x = x ^ (x << 5);
                  gen_state = 64'(x);
                  v = 64'(x);
               end
               mmprng_pkg::MODE_MINSTD: begin
                  gen_state = (64'(x) * 64'd48271) % 64'd2147483647;
                  v = gen_state;
               end
               mmprng_pkg::MODE_LCG31: begin
                  x = x * 32'd1103515245 + 32'd12345;
                  gen_state = 64'(x);
                  v = 64'(x >> 1);
               end
               mmprng_pkg::MODE_LCG15: begin
                  x = x * 32'd214013 + 32'd2531011;
                  gen_state = 64'(x);
                  v = 64'((x >> 16) & 32'h7FFF);
               end
               mmprng_pkg::MODE_LCG48: begin
                  gen_state = (gen_state * mmprng_pkg::L48_MULT + mmprng_pkg::L48_ADD)
                     & mmprng_pkg::L48_MASK;
                  v = gen_state >> 16;
               end
               mmprng_pkg::MODE_PCG32: begin
                  s = gen_state;
                  gen_state = s * mmprng_pkg::PCG_MULT + mmprng_pkg::PCG_INC;
                  xs = 32'(((s >> 18) ^ s) >> 27);
                  r = s[63:59];
                  xs = (xs >> r) | (xs << ((6'd32 - r) & 6'd31));
                  v = 64'(xs);
               end
               default: begin
                  gen_state = gen_state + mmprng_pkg::SM_GAMMA;
                  s = gen_state;
                  s = (s ^ (s >> 30)) * mmprng_pkg::SM_MIX1;
                  s = (s ^ (s >> 27)) * mmprng_pkg::SM_MIX2;
                  v = s ^ (s >> 31);
               end
            endcase
            produced = 1'b1;
            res.raw = v;
            res.pos = position_of(cur_gen_mode, cur_red_mode, v);
            res.boost = boost_class_of(cur_gen_mode, v);
         end
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      begin
         csr_psel = 1'b1;
         csr_pwrite = 1'b1;
         csr_paddr = addr;
         csr_pwdata = value;
         @(negedge clock);
         csr_penable = 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         @(negedge clock);
         csr_psel = 1'b0;
         csr_penable = 1'b0;
         csr_pwrite = 1'b0;
      end
   endtask

   task automatic configure(input logic [2:0] gmode, input logic red);
      begin
         while (pending_draws.size() != 0) @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
         csr_write(ADDR_GEN_MODE, 32'(gmode));
         csr_write(ADDR_REDUCE_MODE, 32'(red));
         cur_gen_mode = gmode;
         cur_red_mode = red;
      end
   endtask

   task automatic send_item(input logic kind, input logic [31:0] seed, input logic typed,
         input draw_result_type typed_res);
      logic produced;
      draw_result_type res;
      begin
         while (!quiet && $urandom_range(0, 99) < 16) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tuser = kind;
         req_tdata = seed;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         predict_item(kind, seed, produced, res);
         if (produced) pending_draws.push_back(typed ? typed_res : res);
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata = $urandom;
      end
   endtask

   always @(negedge clock) begin
      rsp_tready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      draw_result_type want;
      draw_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_draws.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item: %h", rsp_tdata);
         end else begin
            want = pending_draws.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected raw %h pos %0d boost %0d, ",
                     "got raw %h pos %0d boost %0d"},
                     want.raw, want.pos, want.boost, got.raw, got.pos, got.boost);
            end
         end
      end
   end

   initial begin
      logic [31:0] seed;
      logic kind;
      int items;
      int run_len;
      rows = '{
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_XORSHIFT,
           mmprng_pkg::REDUCE_MOD,   1'b1, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'h0,        mmprng_pkg::MODE_XORSHIFT,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_XORSHIFT,
           mmprng_pkg::REDUCE_MOD,   1'b1, 64'd270369, 5'd9, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'hFFFFFFFF, mmprng_pkg::MODE_XORSHIFT,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_XORSHIFT,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'h7FFFFFFF, mmprng_pkg::MODE_MINSTD,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_MINSTD,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'hFFFFFFFF, mmprng_pkg::MODE_MINSTD,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_MINSTD,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'hFFFFFFFF, mmprng_pkg::MODE_LCG31,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_LCG31,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'h0,        mmprng_pkg::MODE_LCG15,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_LCG15,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'h12345678, mmprng_pkg::MODE_LCG48,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_LCG48,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'h0,        mmprng_pkg::MODE_PCG32,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_PCG32,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'hFFFFFFFF, mmprng_pkg::MODE_SPLITMIX,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_SPLITMIX,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_RESEED, 32'h1,        mmprng_pkg::MODE_SPLITMIX_ALT,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_XORSHIFT,
           mmprng_pkg::REDUCE_MOD,   1'b0, 64'd0,      5'd0, 3'd0},
         '{mmprng_pkg::KIND_DRAW,   32'h0,        mmprng_pkg::MODE_SPLITMIX_ALT,
           mmprng_pkg::REDUCE_SCALE, 1'b0, 64'd0,      5'd0, 3'd0}
      };
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = mmprng_pkg::KIND_RESEED;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet = 1'b0;
      cycles = 0;
      mismatches = 0;
      gen_state = '0;
      cur_gen_mode = mmprng_pkg::MODE_XORSHIFT;
      cur_red_mode = mmprng_pkg::REDUCE_MOD;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (rows[i]) begin
         if (rows[i].gen_mode != cur_gen_mode || rows[i].red_mode != cur_red_mode)
            configure(rows[i].gen_mode, rows[i].red_mode);
         send_item(rows[i].kind, rows[i].seed, rows[i].typed,
            '{rows[i].boost, rows[i].pos, rows[i].raw});
      end

      items = 0;
      while (items < 1530) begin
         configure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         quiet = ($urandom_range(0, 5) == 0);
         run_len = $urandom_range(20, 90);
         for (int n = 0; n < run_len && items < 1530; n++) begin
            kind = ($urandom_range(0, 99) < 12) ? mmprng_pkg::KIND_RESEED
                                                : mmprng_pkg::KIND_DRAW;
            case ($urandom_range(0, 9))
               0: seed = 32'h0;
               1: seed = 32'hFFFFFFFF;
               2: seed = 32'h7FFFFFFF;
               default: seed = $urandom;
            endcase
            send_item(kind, seed, 1'b0, '0);
            items++;
         end
         quiet = 1'b0;
      end

      while (pending_draws.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- multi_mode_prng_with_range_reduce.f -----
rtl/mmprng_pkg.sv
rtl/mmprng_mul.sv
rtl/mmprng_reduce.sv
rtl/multi_mode_prng_with_range_reduce.sv
rtl/mmprng_checker.sv
tb/sv/testbench.sv
